@@ sv/arza_pkg.sv @@
`timescale 1ns / 1ps
package arza_pkg;

  localparam int ADDR_W   = 32;
  localparam int PAGES_W  = 21;
  localparam int RIGHTS_W = 3;
  localparam int CFG_W    = 32;

  localparam logic [PAGES_W-1:0]  MAX_PAGES   = 21'd1048576;
  localparam logic [RIGHTS_W-1:0] FULL_RIGHTS = 3'd7;

  typedef enum logic [1:0] {
    OP_FIXED  = 2'd0,
    OP_ANY    = 2'd1,
    OP_FREE   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_USER_BOTTOM = 2'd0,
    CFG_USER_TOP    = 2'd1,
    CFG_KERNEL_TOP  = 2'd2,
    CFG_KERNEL_BRK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LD_HOLD  = 2'd0,
    LD_LEFT  = 2'd1,
    LD_RIGHT = 2'd2,
    LD_NEW   = 2'd3
  } load_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [PAGES_W-1:0]  pages;
    logic [RIGHTS_W-1:0] rights;
    logic                stack;
  } zone_t;

  typedef struct packed {
    logic lookup_hit;
    logic fixed_hit;
    logic fixed_clash;
    logic free_hit;
    logic fit_hit;
  } flags_t;

endpackage

@@ sv/arza_cell.sv @@
`timescale 1ns / 1ps
module arza_cell #(
  parameter int END_W      = 33,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                       clk,
  input  arza_pkg::load_t            load_sel,
  input  arza_pkg::zone_t            left_zone,
  input  arza_pkg::zone_t            right_zone,
  input  arza_pkg::zone_t            new_zone,
  input  logic [END_W-1:0]           prev_end,
  input  logic [END_W-1:0]           addr,
  input  logic [END_W-1:0]           size,
  input  logic [END_W-1:0]           new_end,
  input  logic [arza_pkg::PAGES_W-1:0] req_pages,
  output arza_pkg::zone_t            zone,
  output logic [END_W-1:0]           zone_end,
  output arza_pkg::flags_t           flags
);

  logic [END_W-1:0] base_x;
  logic [END_W-1:0] guard;

  always_ff @(posedge clk) begin
    unique case (load_sel)
      arza_pkg::LD_HOLD:  zone <= zone;
      arza_pkg::LD_LEFT:  zone <= left_zone;
      arza_pkg::LD_RIGHT: zone <= right_zone;
      arza_pkg::LD_NEW:   zone <= new_zone;
    endcase
  end

  always_comb begin
    base_x   = END_W'(zone.base);
    zone_end = base_x + (END_W'(zone.pages) << PAGE_SHIFT);
    guard    = zone.stack ? (END_W'(1) << PAGE_SHIFT) : '0;
    flags.lookup_hit  = (addr >= base_x) && (addr < zone_end);
    flags.fixed_hit   = addr < zone_end;
    flags.fixed_clash = (addr >= base_x) || (new_end > base_x);
    // a stack's guard page is hidden from the caller
    flags.free_hit    = (addr == base_x + guard) &&
                        ({1'b0, req_pages} + 22'(zone.stack) == {1'b0, zone.pages});
    flags.fit_hit     = ({1'b0, prev_end} + {1'b0, size}) <= {1'b0, base_x};
  end

endmodule

@@ sv/address_range_zone_allocator_core.sv @@
`timescale 1ns / 1ps
// Flow: an input beat is taken in the idle state and passes the pick and decide states
//   before its result beat is offered; no new beat is taken until decide is done.
// The steps (accept, pick, decide) run over the cell chain;
//   the decide step waits while a previous result beat is stalled.
// Reset: clears the zone counts, the control state and the result valid, and loads
//   the register defaults; zone cells are not cleared and are read only below the count.
module address_range_zone_allocator_core #(
  parameter int ZONES_PER_SPACE = 32,
  parameter int PAGE_SHIFT      = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] address,
  input  logic [20:0] page_count,
  input  logic        user_space,
  input  logic [2:0]  access_rights,
  input  logic        stack_zone,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] zone_base,
  output logic [20:0] zone_pages,
  output logic [2:0]  zone_rights,
  output logic        zone_is_stack,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int Z     = ZONES_PER_SPACE;
  localparam int CNT_W = $clog2(Z + 1);
  // ends of zones never wrap: one bit above the widest of address and size
  localparam int END_W = ((21 + PAGE_SHIFT > 32) ? (21 + PAGE_SHIFT) : 32) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PICK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] user_bottom, user_top, kernel_top, kernel_brk;

  // captured input beat
  arza_pkg::op_t op_q;
  logic [31:0]   addr_q;
  logic [20:0]   pages_q;
  logic          user_q;
  logic [2:0]    rights_q;
  logic          stack_q;

  // zone counts per table
  logic [CNT_W-1:0] cnt_u, cnt_k;

  // pick results
  logic [CNT_W-1:0] pos_q;
  logic             found_q;
  logic             clash_q;
  logic [END_W-1:0] va_q;
  arza_pkg::zone_t  sel_zone_q;

  // result register
  arza_pkg::status_t status_q;
  arza_pkg::zone_t   out_zone_q;

  // cell chains: u for user space, k for kernel space
  arza_pkg::zone_t  zu [Z];
  arza_pkg::zone_t  zk [Z];
  logic [END_W-1:0] eu [Z];
  logic [END_W-1:0] ek [Z];
  arza_pkg::flags_t fu [Z];
  arza_pkg::flags_t fk [Z];
  arza_pkg::load_t  lu [Z];
  arza_pkg::load_t  lk [Z];

  logic             tbl;
  logic [CNT_W-1:0] cnt_sel;
  logic [END_W-1:0] addr_x, size_x, new_end, imp_end, ub_x, prev0;
  logic [31:0]      kdiff;
  logic [20:0]      imp_pages;

  logic [Z-1:0]     hit, first_oh, clash_vec;
  logic             found;
  logic [CNT_W-1:0] first_idx, pos;
  logic [END_W-1:0] va;
  arza_pkg::zone_t  sel_zone;

  logic              done_fire, do_ins, do_rem, full;
  arza_pkg::status_t res_status;
  arza_pkg::zone_t   res_zone, ins_zone;
  logic [31:0]       ins_base;
  logic [END_W:0]    va_top;

  // shared operands for every cell
  always_comb begin
    tbl       = (op_q == arza_pkg::OP_ANY) ? user_q : (addr_q < user_top);
    cnt_sel   = tbl ? cnt_u : cnt_k;
    addr_x    = END_W'(addr_q);
    size_x    = END_W'(pages_q) << PAGE_SHIFT;
    new_end   = addr_x + size_x;
    kdiff     = kernel_brk - user_top;
    imp_end   = END_W'({1'b0, user_top} + {1'b0, kdiff});
    imp_pages = 21'(kdiff >> PAGE_SHIFT);
    ub_x      = END_W'(user_bottom);
    prev0     = tbl ? ub_x : imp_end;
  end

  for (genvar j = 0; j < Z; j++) begin : g_cell
    arza_cell #(.END_W(END_W), .PAGE_SHIFT(PAGE_SHIFT)) u_cell_u (
      .clk       (clk),
      .load_sel  (lu[j]),
      .left_zone ((j == 0) ? ins_zone : zu[(j == 0) ? 0 : j - 1]),
      .right_zone((j == Z - 1) ? ins_zone : zu[(j == Z - 1) ? j : j + 1]),
      .new_zone  (ins_zone),
      .prev_end  ((j == 0) ? ub_x : eu[(j == 0) ? 0 : j - 1]),
      .addr      (addr_x),
      .size      (size_x),
      .new_end   (new_end),
      .req_pages (pages_q),
      .zone      (zu[j]),
      .zone_end  (eu[j]),
      .flags     (fu[j])
    );
    arza_cell #(.END_W(END_W), .PAGE_SHIFT(PAGE_SHIFT)) u_cell_k (
      .clk       (clk),
      .load_sel  (lk[j]),
      .left_zone ((j == 0) ? ins_zone : zk[(j == 0) ? 0 : j - 1]),
      .right_zone((j == Z - 1) ? ins_zone : zk[(j == Z - 1) ? j : j + 1]),
      .new_zone  (ins_zone),
      .prev_end  ((j == 0) ? imp_end : ek[(j == 0) ? 0 : j - 1]),
      .addr      (addr_x),
      .size      (size_x),
      .new_end   (new_end),
      .req_pages (pages_q),
      .zone      (zk[j]),
      .zone_end  (ek[j]),
      .flags     (fk[j])
    );
  end

  // pick: hit vector of the chosen table, first hit, insert point, fit address
  always_comb begin
    arza_pkg::flags_t f;
    logic live;
    for (int j = 0; j < Z; j++) begin
      f    = tbl ? fu[j] : fk[j];
      live = CNT_W'(j) < cnt_sel;
      unique case (op_q)
        arza_pkg::OP_LOOKUP: hit[j] = live && f.lookup_hit;
        arza_pkg::OP_FREE:   hit[j] = live && f.free_hit;
        arza_pkg::OP_FIXED:  hit[j] = live && f.fixed_hit;
        // user search starts after the first zone
        arza_pkg::OP_ANY:    hit[j] = live && f.fit_hit && !(tbl && (j == 0));
      endcase
      clash_vec[j] = f.fixed_clash;
    end
    first_oh  = hit & (~hit + Z'(1));
    found     = |hit;
    first_idx = '0;
    sel_zone  = '0;
    for (int j = 0; j < Z; j++) begin
      if (first_oh[j]) begin
        first_idx = first_idx | CNT_W'(j);
        sel_zone  = sel_zone | (tbl ? zu[j] : zk[j]);
      end
    end
    pos = found ? first_idx : cnt_sel;
    va  = (pos == '0) ? prev0 : '0;
    for (int k = 1; k <= Z; k++) begin
      if (pos == CNT_W'(k)) begin
        va = va | (tbl ? eu[k - 1] : ek[k - 1]);
      end
    end
  end

  // decide: status, zone to report, table edit
  always_comb begin
    res_status = arza_pkg::ST_OK;
    res_zone   = '0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    ins_base   = addr_q;
    full       = cnt_sel >= CNT_W'(Z);
    va_top     = {1'b0, va_q} + {1'b0, size_x};
    if (op_q == arza_pkg::OP_ANY) begin
      ins_base = va_q[31:0];
    end
    ins_zone = '{base: ins_base, pages: pages_q, rights: rights_q, stack: stack_q};
    if (op_q == arza_pkg::OP_LOOKUP) begin
      // the reserved kernel zone wins over stored zones
      if (!tbl && (addr_q >= user_top) && (addr_x < imp_end)) begin
        res_zone = '{base: user_top, pages: imp_pages,
                     rights: arza_pkg::FULL_RIGHTS, stack: 1'b0};
      end else if (found_q) begin
        res_zone = sel_zone_q;
      end else begin
        res_status = arza_pkg::ST_NOT_FOUND;
      end
    end else if ((pages_q == '0) || (pages_q > arza_pkg::MAX_PAGES)) begin
      res_status = arza_pkg::ST_BAD_ARG;
    end else if (op_q == arza_pkg::OP_FREE) begin
      if (addr_q == user_top) begin
        res_status = arza_pkg::ST_BAD_ARG;
      end else if (found_q) begin
        res_zone = sel_zone_q;
        do_rem   = 1'b1;
      end else begin
        res_status = arza_pkg::ST_NOT_FOUND;
      end
    end else if (op_q == arza_pkg::OP_FIXED) begin
      if (addr_q[PAGE_SHIFT-1:0] != '0) begin
        res_status = arza_pkg::ST_BAD_ARG;
      end else if (tbl ? ((addr_q < user_bottom) || (new_end > END_W'(user_top)))
                       : ((addr_q < user_top) || (new_end > END_W'(kernel_top)))) begin
        res_status = arza_pkg::ST_BAD_ARG;
      end else if (!tbl && (addr_x < imp_end)) begin
        res_status = arza_pkg::ST_NO_ROOM;
      end else if (found_q && clash_q) begin
        res_status = arza_pkg::ST_NO_ROOM;
      end else if (full) begin
        res_status = arza_pkg::ST_FULL;
      end else begin
        res_zone = ins_zone;
        do_ins   = 1'b1;
      end
    end else begin
      if (tbl ? ((va_q < ub_x) || (va_top > (END_W + 1)'(user_top)))
              : ((va_q < END_W'(user_top)) || (va_top > (END_W + 1)'(kernel_top)))) begin
        res_status = arza_pkg::ST_NO_ROOM;
      end else if (full) begin
        res_status = arza_pkg::ST_FULL;
      end else begin
        res_zone = ins_zone;
        do_ins   = 1'b1;
      end
    end
  end

  assign done_fire = (state == S_DONE) && !(out_valid && out_stall);

  // per-cell load select: shift right behind an insert, left over a removal
  always_comb begin
    arza_pkg::load_t ld;
    for (int j = 0; j < Z; j++) begin
      ld = arza_pkg::LD_HOLD;
      if (done_fire && do_ins) begin
        if (CNT_W'(j) > pos_q) begin
          ld = arza_pkg::LD_LEFT;
        end else if (CNT_W'(j) == pos_q) begin
          ld = arza_pkg::LD_NEW;
        end
      end else if (done_fire && do_rem && (CNT_W'(j) >= pos_q)) begin
        ld = arza_pkg::LD_RIGHT;
      end
      lu[j] = tbl ? ld : arza_pkg::LD_HOLD;
      lk[j] = tbl ? arza_pkg::LD_HOLD : ld;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_PICK;
        S_PICK:  state <= S_DONE;
        S_DONE:  if (done_fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q     <= arza_pkg::op_t'(opcode);
      addr_q   <= address;
      pages_q  <= page_count;
      user_q   <= user_space;
      rights_q <= access_rights;
      stack_q  <= stack_zone;
    end
  end

  // hold the pick results for the decide step
  always_ff @(posedge clk) begin
    if (state == S_PICK) begin
      pos_q      <= pos;
      found_q    <= found;
      clash_q    <= |(first_oh & clash_vec);
      va_q       <= va;
      sel_zone_q <= sel_zone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_u <= '0;
      cnt_k <= '0;
    end else if (done_fire) begin
      if (do_ins) begin
        if (tbl) cnt_u <= cnt_u + CNT_W'(1);
        else     cnt_k <= cnt_k + CNT_W'(1);
      end else if (do_rem) begin
        if (tbl) cnt_u <= cnt_u - CNT_W'(1);
        else     cnt_k <= cnt_k - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_bottom <= 32'h0040_0000;
      user_top    <= 32'hC000_0000;
      kernel_top  <= 32'hFFC0_0000;
      kernel_brk  <= 32'hC080_0000;
    end else if (cfg_we) begin
      unique case (arza_pkg::cfg_idx_t'(cfg_index))
        arza_pkg::CFG_USER_BOTTOM: user_bottom <= cfg_data;
        arza_pkg::CFG_USER_TOP:    user_top    <= cfg_data;
        arza_pkg::CFG_KERNEL_TOP:  kernel_top  <= cfg_data;
        arza_pkg::CFG_KERNEL_BRK:  kernel_brk  <= cfg_data;
      endcase
    end
  end

  // result register: load on decide, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      status_q   <= res_status;
      out_zone_q <= res_zone;
    end
  end

  assign status        = status_q;
  assign zone_base     = out_zone_q.base;
  assign zone_pages    = out_zone_q.pages;
  assign zone_rights   = out_zone_q.rights;
  assign zone_is_stack = out_zone_q.stack;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_u <= CNT_W'(Z)) && (cnt_k <= CNT_W'(Z)))
    else $error("zone count beyond table depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_q != arza_pkg::ST_OK)) |->
      ((out_zone_q.base == '0) && (out_zone_q.pages == '0) &&
       (out_zone_q.rights == '0) && !out_zone_q.stack))
    else $error("failed result carries a zone");

  a_accept_pick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PICK))
    else $error("accepted beat did not start a pick");
`endif

endmodule
